// ===== src/bfsp_pkg.sv =====
`default_nettype none

package bfsp_pkg;

   // vertex and field widths are fixed by the channel definition
   localparam int VERTEX_W     = 5;
   localparam int VERTEX_SLOTS = 32;
   localparam int COUNT_W      = 6;
   localparam int WEIGHT_W     = 16;
   localparam int DIST_W       = 32;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   typedef logic [CSR_IDX_W-1:0]    csr_idx_type;
   typedef logic [CSR_DATA_W-1:0]   csr_data_type;
   typedef logic [VERTEX_W-1:0]     vertex_type;
   typedef logic [COUNT_W-1:0]      count_type;
   typedef logic signed [WEIGHT_W-1:0] weight_type;
   typedef logic signed [DIST_W-1:0]   dist_type;

   localparam csr_idx_type CSR_VERTEX_COUNT  = csr_idx_type'(0);
   localparam csr_idx_type CSR_SOURCE_VERTEX = csr_idx_type'(1);

   // status from the relax datapath to the sequencer
   typedef struct packed {
      logic     improve;
      dist_type cand;
   } relax_status_type;

endpackage

`default_nettype wire

// ===== src/bfsp_req_if.sv =====
`default_nettype none

interface bfsp_req_if;
   import bfsp_pkg::*;

   logic       valid;
   logic       ready;
   vertex_type src_vertex;
   vertex_type dst_vertex;
   weight_type edge_weight;
   logic       last_edge;

   modport source (output valid, output src_vertex, output dst_vertex,
                   output edge_weight, output last_edge, input ready);
   modport sink   (input valid, input src_vertex, input dst_vertex,
                   input edge_weight, input last_edge, output ready);
endinterface

`default_nettype wire

// ===== src/bfsp_rsp_if.sv =====
`default_nettype none

interface bfsp_rsp_if;
   import bfsp_pkg::*;

   logic       valid;
   logic       ready;
   vertex_type vertex;
   dist_type   distance;
   logic       reachable;
   logic       negative_cycle;
   logic       last;

   modport source (output valid, output vertex, output distance, output reachable,
                   output negative_cycle, output last, input ready);
   modport sink   (input valid, input vertex, input distance, input reachable,
                   input negative_cycle, input last, output ready);
endinterface

`default_nettype wire

// ===== src/bellman_ford_shortest_paths_top.sv =====
`default_nettype none

// Single-source shortest paths over a loaded edge list.
// req channel: one directed weighted edge per word; the edge is stored in the
// edge memory (words past MAX_EDGES are dropped). A word with last_edge set
// starts the run after storing its edge. Loading accepts one word per cycle.
// csr port: index 0 sets vertex_count, index 1 sets source_vertex; write only
// while the block is idle.
// rsp channel: either one word flagged negative_cycle, or one word per vertex
// 0..n-1 with distance and reachable, last set on vertex n-1.
// Run time: n-1 relax passes plus one check pass over all E stored edges.
// A skipped edge visit passes the edge-read and tail-read states; a relaxed one
// also passes the head-read and update states, as the tail and head distances
// are read one after the other through the single read port of the distance
// memory. The check pass stops at the first edge that still improves.
// Results leave through an output register, one per distance read; the receiver
// may stall at any time and the run simply waits on it. req is ready only
// while no run is in progress.
// Reset (synchronous) clears the edge count, the configuration (vertex_count
// 1, source_vertex 0) and the output valid; no memory clearing is needed.
module bellman_ford_shortest_paths_top #(
   parameter int MAX_EDGES = 256
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   bfsp_req_if.sink                    req_ch,
   bfsp_rsp_if.source                  rsp_ch,
   input  wire logic                   csr_we,
   input  wire bfsp_pkg::csr_idx_type  csr_index,
   input  wire bfsp_pkg::csr_data_type csr_data
);
   import bfsp_pkg::*;

   localparam int ECW    = $clog2(MAX_EDGES + 1);
   localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int EDGE_W = 2 * VERTEX_W + WEIGHT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_EDGE_RD, S_TAIL_RD, S_HEAD_RD, S_UPDATE, S_OUT_RD, S_OUT_SEND, S_NEG_SEND
   } state_type;

   state_type  state_ff, state_in;
   logic [ECW-1:0] edge_count_ff, edge_count_in;
   logic [ECW-1:0] edge_idx_ff, edge_idx_in;
   count_type  pass_ff, pass_in;
   logic       check_ff, check_in;
   count_type  n_ff, n_in;
   count_type  out_idx_ff, out_idx_in;
   logic [VERTEX_SLOTS-1:0] reached_ff, reached_in;
   count_type  cfg_count_ff, cfg_count_in;
   vertex_type cfg_source_ff, cfg_source_in;

   logic       rsp_valid_ff, rsp_valid_in;
   vertex_type rsp_vertex_ff, rsp_vertex_in;
   dist_type   rsp_distance_ff, rsp_distance_in;
   logic       rsp_reachable_ff, rsp_reachable_in;
   logic       rsp_neg_ff, rsp_neg_in;
   logic       rsp_last_ff, rsp_last_in;

   // memory ports
   logic              edge_we, edge_re;
   logic [EAW-1:0]    edge_waddr, edge_raddr;
   logic [EDGE_W-1:0] edge_wdata, edge_rdata;
   logic              dist_we, dist_re;
   vertex_type        dist_waddr, dist_raddr;
   dist_type          dist_wdata, dist_rdata;

   relax_status_type  relax_status;

   vertex_type tail, head;
   weight_type weight;
   logic       accept, start, slot_free, edge_ok, pass_end;
   count_type  n_start;

   bfsp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock (clock),
      .we    (edge_we),
      .waddr (edge_waddr),
      .wdata (edge_wdata),
      .re    (edge_re),
      .raddr (edge_raddr),
      .rdata (edge_rdata)
   );

   bfsp_ram #(.WIDTH(DIST_W), .DEPTH(VERTEX_SLOTS)) u_dist_ram (
      .clock (clock),
      .we    (dist_we),
      .waddr (dist_waddr),
      .wdata (dist_wdata),
      .re    (dist_re),
      .raddr (dist_raddr),
      .rdata (dist_rdata)
   );

   bfsp_relax_unit u_relax (
      .clock        (clock),
      .load         (state_ff == S_HEAD_RD),
      .tail_dist    (dist_rdata),
      .weight       (weight),
      .head_dist    (dist_rdata),
      .head_reached (reached_ff[head]),
      .status       (relax_status)
   );

   // handshake and decode of the stored edge
   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign start        = accept && req_ch.last_edge;
   assign slot_free    = !rsp_valid_ff || rsp_ch.ready;

   assign tail   = edge_rdata[EDGE_W-1 -: VERTEX_W];
   assign head   = edge_rdata[WEIGHT_W +: VERTEX_W];
   assign weight = edge_rdata[WEIGHT_W-1:0];

   assign edge_ok  = ({1'b0, tail} < n_ff) && ({1'b0, head} < n_ff) && reached_ff[tail];
   assign pass_end = ((edge_idx_ff + ECW'(1)) == edge_count_ff);

   // active vertex count, clamped to 1..VERTEX_SLOTS
   always_comb begin
      if (cfg_count_ff == '0) begin
         n_start = count_type'(1);
      end else if (cfg_count_ff > count_type'(VERTEX_SLOTS)) begin
         n_start = count_type'(VERTEX_SLOTS);
      end else begin
         n_start = cfg_count_ff;
      end
   end

   // sequencer next state and memory controls
   always_comb begin
      state_in         = state_ff;
      edge_count_in    = edge_count_ff;
      edge_idx_in      = edge_idx_ff;
      pass_in          = pass_ff;
      check_in         = check_ff;
      n_in             = n_ff;
      out_idx_in       = out_idx_ff;
      reached_in       = reached_ff;
      cfg_count_in     = cfg_count_ff;
      cfg_source_in    = cfg_source_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ch.ready;
      rsp_vertex_in    = rsp_vertex_ff;
      rsp_distance_in  = rsp_distance_ff;
      rsp_reachable_in = rsp_reachable_ff;
      rsp_neg_in       = rsp_neg_ff;
      rsp_last_in      = rsp_last_ff;

      edge_we    = 1'b0;
      edge_waddr = edge_count_ff[EAW-1:0];
      edge_wdata = {req_ch.src_vertex, req_ch.dst_vertex, req_ch.edge_weight};
      edge_re    = 1'b0;
      edge_raddr = edge_idx_ff[EAW-1:0];
      dist_we    = 1'b0;
      dist_waddr = head;
      dist_wdata = relax_status.cand;
      dist_re    = 1'b0;
      dist_raddr = tail;

      // configuration writes
      if (csr_we) begin
         unique case (csr_index)
            CSR_VERTEX_COUNT:  cfg_count_in  = csr_data[COUNT_W-1:0];
            CSR_SOURCE_VERTEX: cfg_source_in = csr_data[VERTEX_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (edge_count_ff < ECW'(MAX_EDGES)) begin
                  edge_we       = 1'b1;
                  edge_count_in = edge_count_ff + ECW'(1);
               end
               // run start: only the source is reached, at distance zero, if it is in range
               if (start) begin
                  n_in        = n_start;
                  reached_in  = '0;
                  if ({1'b0, cfg_source_ff} < n_start) begin
                     reached_in[cfg_source_ff] = 1'b1;
                  end
                  dist_we     = 1'b1;
                  dist_waddr  = cfg_source_ff;
                  dist_wdata  = '0;
                  edge_idx_in = '0;
                  pass_in     = count_type'(1);
                  check_in    = (n_start == count_type'(1));
                  state_in    = S_EDGE_RD;
               end
            end
         end
         S_EDGE_RD: begin
            edge_re  = 1'b1;
            state_in = S_TAIL_RD;
         end
         S_TAIL_RD: begin
            if (edge_ok) begin
               dist_re  = 1'b1;
               state_in = S_HEAD_RD;
            end
         end
         S_HEAD_RD: begin
            dist_re    = 1'b1;
            dist_raddr = head;
            state_in   = S_UPDATE;
         end
         S_UPDATE: begin
            if (relax_status.improve && !check_ff) begin
               dist_we          = 1'b1;
               reached_in[head] = 1'b1;
            end
         end
         S_OUT_RD: begin
            dist_re    = 1'b1;
            dist_raddr = out_idx_ff[VERTEX_W-1:0];
            state_in   = S_OUT_SEND;
         end
         S_OUT_SEND: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_vertex_in    = out_idx_ff[VERTEX_W-1:0];
               rsp_reachable_in = reached_ff[out_idx_ff[VERTEX_W-1:0]];
               rsp_distance_in  = rsp_reachable_in ? dist_rdata : '0;
               rsp_neg_in       = 1'b0;
               rsp_last_in      = ((out_idx_ff + count_type'(1)) == n_ff);
               out_idx_in       = out_idx_ff + count_type'(1);
               if (rsp_last_in) begin
                  edge_count_in = '0;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_OUT_RD;
               end
            end
         end
         S_NEG_SEND: begin
            if (slot_free) begin
               rsp_valid_in     = 1'b1;
               rsp_vertex_in    = '0;
               rsp_distance_in  = '0;
               rsp_reachable_in = 1'b0;
               rsp_neg_in       = 1'b1;
               rsp_last_in      = 1'b1;
               edge_count_in    = '0;
               state_in         = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // step to the next edge, the next pass or the result phase
      if ((state_ff == S_TAIL_RD && !edge_ok) || state_ff == S_UPDATE) begin
         if (state_ff == S_UPDATE && check_ff && relax_status.improve) begin
            state_in = S_NEG_SEND;
         end else if (pass_end) begin
            if (check_ff) begin
               out_idx_in = '0;
               state_in   = S_OUT_RD;
            end else begin
               if ((pass_ff + count_type'(1)) == n_ff) begin
                  check_in = 1'b1;
               end
               pass_in     = pass_ff + count_type'(1);
               edge_idx_in = '0;
               state_in    = S_EDGE_RD;
            end
         end else begin
            edge_idx_in = edge_idx_ff + ECW'(1);
            state_in    = S_EDGE_RD;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edge_count_ff <= '0;
         cfg_count_ff  <= count_type'(1);
         cfg_source_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         reached_ff    <= '0;
      end else begin
         state_ff      <= state_in;
         edge_count_ff <= edge_count_in;
         cfg_count_ff  <= cfg_count_in;
         cfg_source_ff <= cfg_source_in;
         rsp_valid_ff  <= rsp_valid_in;
         reached_ff    <= reached_in;
      end
      edge_idx_ff      <= edge_idx_in;
      pass_ff          <= pass_in;
      check_ff         <= check_in;
      n_ff             <= n_in;
      out_idx_ff       <= out_idx_in;
      rsp_vertex_ff    <= rsp_vertex_in;
      rsp_distance_ff  <= rsp_distance_in;
      rsp_reachable_ff <= rsp_reachable_in;
      rsp_neg_ff       <= rsp_neg_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.vertex         = rsp_vertex_ff;
   assign rsp_ch.distance       = rsp_distance_ff;
   assign rsp_ch.reachable      = rsp_reachable_ff;
   assign rsp_ch.negative_cycle = rsp_neg_ff;
   assign rsp_ch.last           = rsp_last_ff;

   // edge store never overfills
   a_edge_count_bound: assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= ECW'(MAX_EDGES))
      else $error("edge count beyond store depth");

   // the check pass never writes a distance
   a_no_write_in_check: assert property (@(posedge clock) disable iff (reset)
      (dist_we && state_ff != S_IDLE) |-> !check_ff)
      else $error("distance written during cycle check");

   // relaxation only writes heads inside the active vertex range
   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      (dist_we && state_ff == S_UPDATE) |-> ({1'b0, dist_waddr} < n_ff))
      else $error("distance write outside active vertices");

   // a negative cycle word is the only and final word of its run
   a_neg_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_neg_ff) |-> (rsp_last_ff && !rsp_reachable_ff))
      else $error("malformed negative cycle word");

   // a run leaves the result phase with the edge store emptied
   a_store_emptied: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_OUT_SEND || state_ff == S_NEG_SEND) && state_in == S_IDLE)
      |=> (edge_count_ff == '0))
      else $error("edge store not emptied after run");

endmodule

`default_nettype wire

// ===== src/bfsp_ram.sv =====
`default_nettype none

module bfsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic             re,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== src/bfsp_relax_unit.sv =====
`default_nettype none

module bfsp_relax_unit (
   input  wire logic                       clock,
   input  wire logic                       load,
   input  wire bfsp_pkg::dist_type         tail_dist,
   input  wire bfsp_pkg::weight_type       weight,
   input  wire bfsp_pkg::dist_type         head_dist,
   input  wire logic                       head_reached,
   output bfsp_pkg::relax_status_type      status
);
   import bfsp_pkg::*;

   logic signed [DIST_W:0] sum;
   dist_type               sat_sum;
   dist_type               cand_ff;
   dist_type               cand_in;

   // wide sum, clamped to the signed 32-bit range
   always_comb begin
      sum = {tail_dist[DIST_W-1], tail_dist} + (DIST_W+1)'(weight);
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         sat_sum = sum[DIST_W] ? {1'b1, {(DIST_W-1){1'b0}}} : {1'b0, {(DIST_W-1){1'b1}}};
      end else begin
         sat_sum = sum[DIST_W-1:0];
      end
      cand_in = load ? sat_sum : cand_ff;
   end

   always_ff @(posedge clock) begin
      cand_ff <= cand_in;
   end

   // candidate beats the head when the head is unreached or strictly larger
   always_comb begin
      status.cand    = cand_ff;
      status.improve = !head_reached || (cand_ff < head_dist);
   end

endmodule

`default_nettype wire

// ===== tb/bellman_ford_shortest_paths_top_tb.sv =====
module bellman_ford_shortest_paths_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfsp_pkg::*;

   localparam int EDGE_DEPTH    = 256;
   localparam int RAND_ITEMS    = 150;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 40;

   typedef struct packed {
      vertex_type src_vertex;
      vertex_type dst_vertex;
      weight_type edge_weight;
      logic       last_edge;
   } edge_word_type;

   typedef struct packed {
      vertex_type vertex;
      dist_type   distance;
      logic       reachable;
      logic       negative_cycle;
      logic       last;
   } dist_word_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         csr_we    = 1'b0;
   csr_idx_type  csr_index = '0;
   csr_data_type csr_data  = '0;

   bfsp_req_if req_ch ();
   bfsp_rsp_if rsp_ch ();

   bellman_ford_shortest_paths_top #(
      .MAX_EDGES (EDGE_DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // edge words waiting to be sent and distance words still owed by the block
   edge_word_type pending_edges[$];
   dist_word_type expected_dists[$];
   edge_word_type cur_edge;
   int            edges_outstanding = 0;
   int            error_count       = 0;
   int            send_idle_pct     = 24;
   int            recv_idle_pct     = 70;

   // shadow of the configuration registers
   count_type  vcount_reg = count_type'(1);
   vertex_type source_reg = '0;

   // shadow of the edge list and distance table
   vertex_type edge_tail_mem[EDGE_DEPTH];
   vertex_type edge_head_mem[EDGE_DEPTH];
   weight_type edge_weight_mem[EDGE_DEPTH];
   int         stored_edges = 0;
   dist_type   dist_mem[VERTEX_SLOTS];
   logic       reached[VERTEX_SLOTS];

   always #5ns clock = ~clock;

   function automatic int active_count(count_type vc);
      if (vc == 0) return 1;
      if (vc > VERTEX_SLOTS) return VERTEX_SLOTS;
      return int'(vc);
   endfunction

   // tail distance plus weight, formed wide and clamped to 32 bits
   function automatic dist_type clamp_sum(dist_type a, weight_type w);
      longint s;
      s = longint'(a) + longint'(w);
      if (s > 64'sd2147483647) return dist_type'(32'h7fff_ffff);
      if (s < -64'sd2147483648) return dist_type'(32'h8000_0000);
      return dist_type'(s);
   endfunction

   // one sweep over the stored edges in load order; true if any edge improves
   function automatic bit relax_edges(int n, bit apply);
      bit       improved;
      int       u;
      int       v;
      dist_type cand;
      improved = 1'b0;
      for (int e = 0; e < stored_edges; e++) begin
         u = edge_tail_mem[e];
         v = edge_head_mem[e];
         if (u >= n || v >= n || !reached[u]) continue;
         cand = clamp_sum(dist_mem[u], edge_weight_mem[e]);
         if (!reached[v] || cand < dist_mem[v]) begin
            improved = 1'b1;
            if (apply) begin
               dist_mem[v] = cand;
               reached[v]  = 1'b1;
            end
         end
      end
      return improved;
   endfunction

   // store one accepted edge word; on the final edge work out the distance words
   function automatic void shortest_paths_step(edge_word_type ew);
      int            n;
      dist_word_type dw;
      if (stored_edges < EDGE_DEPTH) begin
         edge_tail_mem[stored_edges]   = ew.src_vertex;
         edge_head_mem[stored_edges]   = ew.dst_vertex;
         edge_weight_mem[stored_edges] = ew.edge_weight;
         stored_edges++;
      end
      if (!ew.last_edge) return;
      n = active_count(vcount_reg);
      for (int i = 0; i < VERTEX_SLOTS; i++) begin
         dist_mem[i] = '0;
         reached[i]  = 1'b0;
      end
      if (source_reg < n) reached[source_reg] = 1'b1;
      for (int pass = 1; pass < n; pass++) void'(relax_edges(n, 1'b1));
      if (relax_edges(n, 1'b0)) begin
         stored_edges = 0;
         dw = '{vertex: '0, distance: '0, reachable: 1'b0, negative_cycle: 1'b1,
                last: 1'b1};
         expected_dists.push_back(dw);
         return;
      end
      stored_edges = 0;
      for (int i = 0; i < n; i++) begin
         dw.vertex         = vertex_type'(i);
         dw.distance       = reached[i] ? dist_mem[i] : dist_type'(0);
         dw.reachable      = reached[i];
         dw.negative_cycle = 1'b0;
         dw.last           = (i == n - 1);
         expected_dists.push_back(dw);
      end
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // edge word driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            shortest_paths_step(cur_edge);
            edges_outstanding--;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_edges.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               cur_edge = pending_edges.pop_front();
               req_ch.valid       <= 1'b1;
               req_ch.src_vertex  <= cur_edge.src_vertex;
               req_ch.dst_vertex  <= cur_edge.dst_vertex;
               req_ch.edge_weight <= cur_edge.edge_weight;
               req_ch.last_edge   <= cur_edge.last_edge;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // distance word monitor and checker
   always @(posedge clock) begin
      dist_word_type exp_word;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_dists.size() == 0) begin
               report_mismatch($sformatf("unexpected word for vertex %0d", rsp_ch.vertex));
            end else begin
               exp_word = expected_dists.pop_front();
               if (rsp_ch.vertex !== exp_word.vertex)
                  report_mismatch($sformatf("vertex got %0d expected %0d",
                                            rsp_ch.vertex, exp_word.vertex));
               if (rsp_ch.distance !== exp_word.distance)
                  report_mismatch($sformatf("vertex %0d distance got %0d expected %0d",
                                            exp_word.vertex, rsp_ch.distance,
                                            exp_word.distance));
               if (rsp_ch.reachable !== exp_word.reachable)
                  report_mismatch($sformatf("vertex %0d reachable got %b expected %b",
                                            exp_word.vertex, rsp_ch.reachable,
                                            exp_word.reachable));
               if (rsp_ch.negative_cycle !== exp_word.negative_cycle)
                  report_mismatch($sformatf("vertex %0d negative_cycle got %b expected %b",
                                            exp_word.vertex, rsp_ch.negative_cycle,
                                            exp_word.negative_cycle));
               if (rsp_ch.last !== exp_word.last)
                  report_mismatch($sformatf("vertex %0d last got %b expected %b",
                                            exp_word.vertex, rsp_ch.last, exp_word.last));
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic add_edge(int src, int dst, int weight, bit last_flag);
      edge_word_type ew;
      ew.src_vertex  = vertex_type'(src);
      ew.dst_vertex  = vertex_type'(dst);
      ew.edge_weight = weight_type'(weight);
      ew.last_edge   = last_flag;
      pending_edges.push_back(ew);
      edges_outstanding++;
   endtask

   // block is idle once every edge is taken and every distance word is back
   task automatic wait_idle();
      while (edges_outstanding != 0 || expected_dists.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, csr_data_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_VERTEX_COUNT:  vcount_reg = count_type'(val);
         CSR_SOURCE_VERTEX: source_reg = vertex_type'(val);
         default: ;
      endcase
   endtask

   task automatic configure(int vc, int src_word);
      wait_idle();
      write_reg(CSR_VERTEX_COUNT, csr_data_type'(vc));
      write_reg(CSR_SOURCE_VERTEX, csr_data_type'(src_word));
   endtask

   // stimulus
   initial begin
      int random_items;
      int vc;
      int n;
      int src_sel;
      int num_edges;
      int tail;
      int head;
      int wgt;

      req_ch.valid       = 1'b0;
      req_ch.src_vertex  = '0;
      req_ch.dst_vertex  = '0;
      req_ch.edge_weight = '0;
      req_ch.last_edge   = 1'b0;
      rsp_ch.ready       = 1'b0;
      random_items       = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration, single vertex with a zero self loop
      add_edge(0, 0, 0, 1'b1);

      // weight extremes along a chain, out-of-range edge ignored
      configure(4, 0);
      add_edge(0, 1, 32767, 1'b0);
      add_edge(1, 2, -32768, 1'b0);
      add_edge(31, 31, -1, 1'b0);
      add_edge(2, 3, -1, 1'b1);

      // reachable negative cycle
      configure(3, 0);
      add_edge(0, 1, 5, 1'b0);
      add_edge(1, 2, -3, 1'b0);
      add_edge(2, 1, -3, 1'b1);

      // negative cycle not reachable from the source, full vertex range
      configure(32, 0);
      add_edge(0, 1, 2, 1'b0);
      add_edge(2, 3, -5, 1'b0);
      add_edge(3, 2, 1, 1'b1);

      // source beyond vertex range, nothing reachable
      configure(5, 6'h3f);
      add_edge(0, 1, 1, 1'b1);

      // zero vertex count acts as one; negative self loop on the source
      configure(0, 0);
      add_edge(0, 0, -1, 1'b1);

      // vertex count above the maximum, source at the top index
      configure(63, 31);
      add_edge(31, 0, 100, 1'b0);
      add_edge(0, 15, -7, 1'b1);

      // vertex count changed between loading and the run
      configure(2, 0);
      add_edge(0, 3, 4, 1'b0);
      wait_idle();
      write_reg(CSR_VERTEX_COUNT, csr_data_type'(4));
      add_edge(3, 2, -2, 1'b1);

      // random graphs
      while (random_items < RAND_ITEMS) begin
         wait_idle();
         case (random_items * 3 / RAND_ITEMS)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 70;
            end
            1: begin
               send_idle_pct = 70;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case ($urandom_range(15))
            0:       vc = 0;
            1:       vc = 1;
            2, 3:    vc = $urandom_range(32, 63);
            default: vc = $urandom_range(2, 8);
         endcase
         n = active_count(count_type'(vc));
         src_sel = ($urandom_range(9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
         src_sel = src_sel | ($urandom_range(1) << 5);
         configure(vc, src_sel);
         num_edges = (n > 8) ? $urandom_range(1, 24) : $urandom_range(1, 12);
         for (int i = 0; i < num_edges; i++) begin
            tail = ($urandom_range(11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
            head = ($urandom_range(11) == 0) ? $urandom_range(0, 31) : $urandom_range(0, n - 1);
            case ($urandom_range(9))
               0:       wgt = $urandom_range(0, 65535);
               1, 2:    wgt = -int'($urandom_range(1, 20));
               default: wgt = $urandom_range(0, 60);
            endcase
            add_edge(tail, head, wgt, i == num_edges - 1);
         end
         random_items += num_edges;
      end

      // drain and verdict
      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_dists.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10ms;
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== files.f =====
src/bfsp_pkg.sv
src/bfsp_req_if.sv
src/bfsp_rsp_if.sv
src/bfsp_ram.sv
src/bfsp_relax_unit.sv
src/bellman_ford_shortest_paths_top.sv
tb/bellman_ford_shortest_paths_top_tb.sv
